// ===== sv/owp_pkg.sv =====
// Shared types, constants and helper functions of the omni waypoint controller.
package owp_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAIN_X       = 3'd0,
        CFG_GAIN_Y       = 3'd1,
        CFG_GAIN_HEADING = 3'd2,
        CFG_POS_TOL      = 3'd3,
        CFG_HEAD_TOL     = 3'd4,
        CFG_WP_COUNT     = 3'd5
    } cfg_index_t;

    // Item opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POSE = 1'b1;

    // CORDIC datapath width and the gain compensation start value (Q2.30).
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam int ATAN_DEPTH = 24;

    // Shared multiplier operand and product widths.
    localparam int MA = 34;
    localparam int MB = 19;
    localparam int MP = MA + MB;

    typedef logic signed [CW-1:0] cordic_word_t;
    typedef logic signed [MP-1:0] prod_t;

    // Arctangent of 2^-i with 2^31 standing for pi.
    function automatic cordic_word_t atan_entry(input logic [4:0] i);
        cordic_word_t r;
        case (i)
            5'd0:  r = 34'sh020000000;
            5'd1:  r = 34'sh012E4051D;
            5'd2:  r = 34'sh009FB385B;
            5'd3:  r = 34'sh0051111D4;
            5'd4:  r = 34'sh0028B0D43;
            5'd5:  r = 34'sh00145D7E1;
            5'd6:  r = 34'sh000A2F61E;
            5'd7:  r = 34'sh000517C55;
            5'd8:  r = 34'sh00028BE53;
            5'd9:  r = 34'sh000145F2E;
            5'd10: r = 34'sh0000A2F98;
            5'd11: r = 34'sh0000517CC;
            5'd12: r = 34'sh000028BE6;
            5'd13: r = 34'sh0000145F3;
            5'd14: r = 34'sh00000A2F9;
            5'd15: r = 34'sh00000517C;
            5'd16: r = 34'sh0000028BE;
            5'd17: r = 34'sh00000145F;
            5'd18: r = 34'sh000000A2F;
            5'd19: r = 34'sh000000517;
            5'd20: r = 34'sh00000028B;
            5'd21: r = 34'sh000000145;
            5'd22: r = 34'sh0000000A2;
            5'd23: r = 34'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round half up by 2^12, then saturate to 16 bits signed.
    function automatic logic signed [15:0] scale_sat(input prod_t p);
        prod_t t;
        t = (p + prod_t'(2048)) >>> 12;
        if (t > prod_t'(32767)) begin
            return 16'sh7FFF;
        end else if (t < -prod_t'(32768)) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

endpackage

// ===== sv/omni_waypoint_p_controller_core.sv =====
// Top level of the omni waypoint proportional controller with table and sequencer.
//
// Usage: the s_ channel takes items. A load item (opcode 0) writes x, y and
// heading into the waypoint table at slot and returns nothing. A pose item
// (opcode 1) returns one velocity command on the m_ channel. An active pose
// goes through one table read, the CORDIC iterations and a sequence of steps
// on the one shared multiplier, which handles rotation, distance, tolerance
// and gains. A pose past the last waypoint returns a stop command directly,
// without the table read, the CORDIC or the multiplier steps.
// s_ready is high only while the sequencer is idle; one item is in work at a
// time, so a new pose is taken only after the last one has finished, while
// loads can follow back to back.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver only holds the following result.
// The cfg_ channel writes gains, tolerances and waypoint count at any time
// and is always ready. Reset restores register defaults and the target
// pointer to zero; table contents are undefined until loaded.
module omni_waypoint_p_controller_core #(
    parameter int MAX_WAYPOINTS = 256,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [7:0]         s_slot,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic signed [15:0] s_heading,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_vel_forward,
    output logic signed [15:0] m_vel_lateral,
    output logic signed [15:0] m_turn_rate,
    output logic               m_reached,
    output logic               m_done_res,
    output logic [8:0]         m_target_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import owp_pkg::*;

    localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_ROT, S_MUL, S_FIN} state_t;

    // Configuration registers.
    logic [15:0] gain_x_reg, gain_y_reg, gain_h_reg;
    logic [14:0] pos_tol_reg, head_tol_reg;
    logic [8:0]  wp_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_x_reg   <= 16'd4096;
            gain_y_reg   <= 16'd4096;
            gain_h_reg   <= 16'd2048;
            pos_tol_reg  <= 15'd102;
            head_tol_reg <= 15'd1565;
            wp_count_reg <= 9'd0;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN_X:       gain_x_reg   <= cfg_data;
                CFG_GAIN_Y:       gain_y_reg   <= cfg_data;
                CFG_GAIN_HEADING: gain_h_reg   <= cfg_data;
                CFG_POS_TOL:      pos_tol_reg  <= cfg_data[14:0];
                CFG_HEAD_TOL:     head_tol_reg <= cfg_data[14:0];
                CFG_WP_COUNT:     wp_count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Waypoint table, 48 bits per entry: heading, y, x.
    logic [47:0] wp_mem [MAX_WAYPOINTS];
    logic [47:0] wp_rd_reg;
    logic [8:0]  ptr_reg;
    logic        s_acc, load_en;

    assign s_acc   = s_valid && s_ready;
    assign load_en = s_acc && (s_opcode == OP_LOAD) && (32'(s_slot) < MAX_WAYPOINTS);

    always_ff @(posedge aclk) begin
        if (load_en) begin
            wp_mem[AW'(s_slot)] <= {s_heading, s_pos_y, s_pos_x};
        end
        wp_rd_reg <= wp_mem[AW'(ptr_reg)];
    end

    // Effective waypoint count, clamped to the table depth.
    logic [31:0] count_eff;
    logic        finished;
    assign count_eff = (32'(wp_count_reg) > MAX_WAYPOINTS) ? 32'(MAX_WAYPOINTS)
                                                          : 32'(wp_count_reg);
    assign finished  = 32'(ptr_reg) >= count_eff;

    // Sequencer and datapath registers.
    state_t state_reg;
    logic signed [15:0] px_reg, py_reg, ph_reg;
    logic signed [16:0] ex_reg, ey_reg, ah_reg;
    logic signed [15:0] eh_reg;
    cordic_word_t c_reg, s_reg;
    logic [3:0]   mstep_reg;
    prod_t        mul_reg, acc_reg, d2_reg;
    logic signed [MB-1:0] rx_reg, ry_reg;
    logic         dist_ok_reg;
    logic signed [15:0] vf_reg, vl_reg, tr_reg;
    logic         done_flag_reg;
    logic         cordic_start, cordic_done;
    cordic_word_t cos_w, sin_w;

    logic signed [15:0] wx, wy, wh, eh_w;
    assign wx   = wp_rd_reg[15:0];
    assign wy   = wp_rd_reg[31:16];
    assign wh   = wp_rd_reg[47:32];
    assign eh_w = wh - ph_reg;

    assign cordic_start = (state_reg == S_READ);

    owp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .theta   (ph_reg),
        .done    (cordic_done),
        .cos_o   (cos_w),
        .sin_o   (sin_w)
    );

    // Shared multiplier operand selection by step.
    logic signed [MA-1:0] op_a;
    logic signed [MB-1:0] op_b;
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (mstep_reg)
            4'd0: begin op_a = c_reg;                 op_b = MB'(ex_reg); end
            4'd1: begin op_a = s_reg;                 op_b = MB'(ey_reg); end
            4'd2: begin op_a = c_reg;                 op_b = MB'(ey_reg); end
            4'd3: begin op_a = s_reg;                 op_b = MB'(ex_reg); end
            4'd4: begin op_a = MA'(ex_reg);           op_b = MB'(ex_reg); end
            4'd5: begin op_a = MA'(ey_reg);           op_b = MB'(ey_reg); end
            4'd6: begin op_a = MA'({1'b0, pos_tol_reg});
                        op_b = MB'({1'b0, pos_tol_reg}); end
            4'd7: begin op_a = MA'({1'b0, gain_x_reg}); op_b = rx_reg; end
            4'd8: begin op_a = MA'({1'b0, gain_y_reg}); op_b = ry_reg; end
            4'd9: begin op_a = MA'({1'b0, gain_h_reg}); op_b = MB'(eh_reg); end
            default: ;
        endcase
    end

    // Rounded shift by 2^30 of the rotation sums.
    prod_t rot_sum, rot_diff, rot_sum_r, rot_diff_r;
    assign rot_sum    = acc_reg + mul_reg;
    assign rot_diff   = acc_reg - mul_reg;
    assign rot_sum_r  = (rot_sum + (prod_t'(1) <<< 29)) >>> 30;
    assign rot_diff_r = (rot_diff + (prod_t'(1) <<< 29)) >>> 30;

    logic hit;
    assign hit = dist_ok_reg && (ah_reg < $signed({2'b0, head_tol_reg}));

    // Main sequencer with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            m_valid   <= 1'b0;
            mstep_reg <= '0;
        end else begin
            if (m_valid && m_ready && (state_reg != S_FIN)) begin
                m_valid <= 1'b0;
            end
            mul_reg <= op_a * op_b;
            case (state_reg)
                S_IDLE: begin
                    if (s_acc && s_opcode == OP_POSE) begin
                        px_reg <= s_pos_x;
                        py_reg <= s_pos_y;
                        ph_reg <= s_heading;
                        if (finished) begin
                            done_flag_reg <= 1'b1;
                            vf_reg        <= '0;
                            vl_reg        <= '0;
                            tr_reg        <= '0;
                            dist_ok_reg   <= 1'b0;
                            ah_reg        <= 17'sd65535;
                            state_reg     <= S_FIN;
                        end else begin
                            done_flag_reg <= 1'b0;
                            state_reg     <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    ex_reg    <= {wx[15], wx} - {px_reg[15], px_reg};
                    ey_reg    <= {wy[15], wy} - {py_reg[15], py_reg};
                    eh_reg    <= eh_w;
                    ah_reg    <= eh_w[15] ? -{eh_w[15], eh_w} : {eh_w[15], eh_w};
                    state_reg <= S_ROT;
                end
                S_ROT: begin
                    if (cordic_done) begin
                        c_reg     <= cos_w;
                        s_reg     <= sin_w;
                        mstep_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 4'd1;
                    case (mstep_reg)
                        4'd1:  acc_reg     <= mul_reg;
                        4'd2:  rx_reg      <= rot_sum_r[MB-1:0];
                        4'd3:  acc_reg     <= mul_reg;
                        4'd4:  ry_reg      <= rot_diff_r[MB-1:0];
                        4'd5:  acc_reg     <= mul_reg;
                        4'd6:  d2_reg      <= rot_sum;
                        4'd7:  dist_ok_reg <= d2_reg < mul_reg;
                        4'd8:  vf_reg      <= scale_sat(mul_reg);
                        4'd9:  vl_reg      <= scale_sat(mul_reg);
                        4'd10: begin
                            tr_reg    <= scale_sat(mul_reg);
                            state_reg <= S_FIN;
                        end
                        default: ;
                    endcase
                end
                S_FIN: begin
                    if (!m_valid || m_ready) begin
                        m_valid        <= 1'b1;
                        m_vel_forward  <= vf_reg;
                        m_vel_lateral  <= vl_reg;
                        m_turn_rate    <= tr_reg;
                        m_reached      <= hit && !done_flag_reg;
                        m_done_res     <= done_flag_reg;
                        m_target_index <= ptr_reg;
                        if (hit && !done_flag_reg) begin
                            ptr_reg <= ptr_reg + 9'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

// ===== sv/owp_cordic.sv =====
// Iterative CORDIC unit giving cosine and sine (Q2.30) of a binary angle.
module owp_cordic #(
    parameter int STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [15:0]    theta,
    output logic                  done,
    output owp_pkg::cordic_word_t cos_o,
    output owp_pkg::cordic_word_t sin_o
);
    import owp_pkg::*;

    localparam logic [4:0] LAST = 5'(((STEPS < ATAN_DEPTH) ? STEPS : ATAN_DEPTH) - 1);

    cordic_word_t x_reg, y_reg, z_reg;
    logic [4:0]   i_reg;
    logic         run_reg, flip_reg, done_reg;
    logic         fold;
    logic signed [15:0] theta_f;
    cordic_word_t dx, dy;

    // Fold the angle into plus/minus pi/2 and note the sign flip.
    assign fold    = (theta > 16'sd16384) || (theta < -16'sd16384);
    assign theta_f = fold ? (theta + 16'sh8000) : theta;

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    // One micro-rotation per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= CORDIC_GAIN_INV;
                y_reg    <= '0;
                z_reg    <= {{2{theta_f[15]}}, theta_f, 16'b0};
                flip_reg <= fold;
                i_reg    <= '0;
                run_reg  <= 1'b1;
            end else if (run_reg) begin
                if (!z_reg[CW-1]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_entry(i_reg);
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_entry(i_reg);
                end
                i_reg <= i_reg + 5'd1;
                if (i_reg == LAST) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign cos_o = flip_reg ? -x_reg : x_reg;
    assign sin_o = flip_reg ? -y_reg : y_reg;

endmodule

// ===== tb/tb_omni_waypoint_p_controller_core.sv =====
// Self-checking testbench for the omni waypoint proportional controller core.
`timescale 1ns / 100ps

module tb_omni_waypoint_p_controller_core;
    import owp_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int CORDIC_ROUNDS = 16;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 1500;
    localparam int RANDOM_ITEMS  = 1000;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [15:0] vel_forward;
        logic signed [15:0] vel_lateral;
        logic signed [15:0] turn_rate;
        logic               reached;
        logic               done_res;
        logic [8:0]         target_index;
    } command_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               opcode;
        logic [7:0]         slot;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] ph;
        logic [2:0]         reg_index;
        logic [15:0]        reg_data;
        logic               pinned;
        command_t           pinned_cmd;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_opcode;
    logic [7:0]         s_slot;
    logic signed [15:0] s_pos_x;
    logic signed [15:0] s_pos_y;
    logic signed [15:0] s_heading;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_vel_forward;
    logic signed [15:0] m_vel_lateral;
    logic signed [15:0] m_turn_rate;
    logic               m_reached;
    logic               m_done_res;
    logic [8:0]         m_target_index;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    omni_waypoint_p_controller_core uut (.*);

    // Shadow of the block's table, pointer and registers.
    logic signed [15:0] wp_x [TABLE_DEPTH];
    logic signed [15:0] wp_y [TABLE_DEPTH];
    logic signed [15:0] wp_h [TABLE_DEPTH];
    bit                 wp_loaded [TABLE_DEPTH];
    int                 target_ptr;
    logic [15:0]        gain_x = 16'd4096;
    logic [15:0]        gain_y = 16'd4096;
    logic [15:0]        gain_heading = 16'd2048;
    logic [14:0]        pos_tol = 15'd102;
    logic [14:0]        head_tol = 15'd1565;
    logic [8:0]         wp_count = 9'd0;

    command_t expected_cmds[$];
    bit       pin_pending;
    command_t pin_cmd;
    int       mismatches;
    int       items_sent;
    int       out_hold;
    int       results_taken;
    int       stalls_drawn;
    bit       calm;
    int       idle_cycles;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Expected command for one pose; advances the shadow pointer on a hit.
    function automatic command_t predict_pose(input logic signed [15:0] px,
                                              input logic signed [15:0] py,
                                              input logic signed [15:0] ph);
        command_t r;
        int eff_count, theta;
        longint ex, ey, eh, cx, sy, z, dx, dy, rx, ry, d2, tol2, ah;
        logic signed [15:0] eh16, folded;
        bit flip, hit;
        eff_count = (wp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(wp_count);
        r = '0;
        r.target_index = target_ptr[8:0];
        if (target_ptr >= eff_count) begin
            r.done_res = 1'b1;
            return r;
        end
        ex = longint'(wp_x[target_ptr]) - longint'(px);
        ey = longint'(wp_y[target_ptr]) - longint'(py);
        eh16 = wp_h[target_ptr] - ph;
        eh = longint'(eh16);
        // Sine and cosine of the robot heading, folded by pi into the CORDIC range.
        theta = int'(ph);
        flip = 1'b0;
        if (theta > 16384 || theta < -16384) begin
            flip = 1'b1;
            folded = 16'(theta + 32768);
            theta = int'(folded);
        end
        z = longint'(theta) * 65536;
        cx = 652032874;
        sy = 0;
        for (int i = 0; i < CORDIC_ROUNDS; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx; sy += dy; z -= longint'(atan_entry(5'(i)));
            end else begin
                cx += dx; sy -= dy; z += longint'(atan_entry(5'(i)));
            end
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        rx = (cx * ex + sy * ey + (longint'(1) <<< 29)) >>> 30;
        ry = (cx * ey - sy * ex + (longint'(1) <<< 29)) >>> 30;
        r.vel_forward = clip16((longint'(gain_x) * rx + 2048) >>> 12);
        r.vel_lateral = clip16((longint'(gain_y) * ry + 2048) >>> 12);
        r.turn_rate = clip16((longint'(gain_heading) * eh + 2048) >>> 12);
        d2 = ex * ex + ey * ey;
        tol2 = longint'(pos_tol) * longint'(pos_tol);
        ah = (eh < 0) ? -eh : eh;
        hit = (d2 < tol2) && (ah < longint'(head_tol));
        r.reached = hit;
        if (hit) target_ptr = target_ptr + 1;
        return r;
    endfunction

    // Handshake monitor: register writes, item prediction and result checking.
    always @(posedge aclk) begin
        command_t got, want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GAIN_X:       gain_x = cfg_data;
                    CFG_GAIN_Y:       gain_y = cfg_data;
                    CFG_GAIN_HEADING: gain_heading = cfg_data;
                    CFG_POS_TOL:      pos_tol = cfg_data[14:0];
                    CFG_HEAD_TOL:     head_tol = cfg_data[14:0];
                    CFG_WP_COUNT:     wp_count = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_LOAD) begin
                    wp_x[s_slot] = s_pos_x;
                    wp_y[s_slot] = s_pos_y;
                    wp_h[s_slot] = s_heading;
                    wp_loaded[s_slot] = 1'b1;
                end else begin
                    want = predict_pose(s_pos_x, s_pos_y, s_heading);
                    if (pin_pending) want = pin_cmd;
                    expected_cmds = {expected_cmds, want};
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_vel_forward, m_vel_lateral, m_turn_rate, m_reached,
                        m_done_res, m_target_index};
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected command: %p", got);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("command mismatch: expected %p, got %p", want, got);
                    end
                end
                results_taken++;
            end
        end
    end

    // Receiver backpressure, one drawn stall per result.
    always @(negedge aclk) begin
        if (stalls_drawn != results_taken) begin
            stalls_drawn = results_taken;
            out_hold = calm ? 0 : $urandom_range(0, 14);
        end
        if (out_hold > 0) begin
            m_ready <= 1'b0;
            out_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("omni_waypoint_p_controller_core verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] slot,
                             input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic signed [15:0] ph);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        repeat (gap) @(negedge aclk);
        s_valid = 1'b1;
        s_opcode = op;
        s_slot = slot;
        s_pos_x = px;
        s_pos_y = py;
        s_heading = ph;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        items_sent++;
    endtask

    // Wait until every command has arrived and the block has gone quiet.
    task automatic settle();
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Loads random waypoints into every unloaded slot from lo up to hi - 1.
    task automatic fill_slots(input int lo, input int hi);
        for (int i = lo; i < hi; i++) begin
            if (!wp_loaded[i])
                send_item(OP_LOAD, 8'(i), 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    function automatic stim_row_t item_row(input logic op, input logic [7:0] slot,
                                           input int px, input int py, input int ph);
        stim_row_t r;
        r = '{ROW_ITEM, op, slot, 16'(px), 16'(py), 16'(ph), 3'd0, 16'd0, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] idx, input int data);
        stim_row_t r;
        r = '{ROW_CFG, 1'b0, 8'd0, 16'd0, 16'd0, 16'd0, idx, 16'(data), 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t pinned_row(input int px, input int py, input int ph,
                                             input command_t c);
        stim_row_t r;
        r = item_row(OP_POSE, 8'd0, px, py, ph);
        r.pinned = 1'b1;
        r.pinned_cmd = c;
        return r;
    endfunction

    stim_row_t directed[$];

    // Appends one row to the directed table.
    function automatic void add_row(input stim_row_t r);
        directed = {directed, r};
    endfunction

    initial begin
        int eff, t, wp, sel, cnt;
        logic [15:0] word;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_LOAD;
        s_slot = '0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_heading = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GAIN_X;
        cfg_data = '0;
        calm = 1'b0;
        items_sent = 0;
        pin_pending = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows: reset state, extreme fields, each register, special cases.
        add_row(pinned_row(-32768, 32767, -32768, '{0, 0, 0, 0, 1, 0}));
        add_row(item_row(OP_LOAD, 8'd0, 0, 0, 0));
        add_row(item_row(OP_LOAD, 8'd1, 32767, 32767, 32767));
        add_row(item_row(OP_LOAD, 8'd2, -32768, -32768, -32768));
        add_row(item_row(OP_LOAD, 8'd3, 100, -200, 16384));
        add_row(item_row(OP_LOAD, 8'd255, 1, 2, 3));
        add_row(cfg_row(CFG_WP_COUNT, 4));
        add_row(pinned_row(0, 0, 0, '{0, 0, 0, 1, 0, 0}));
        add_row(item_row(OP_POSE, 8'd0, -32768, -32768, -32768));
        add_row(cfg_row(CFG_GAIN_X, 65535));
        add_row(cfg_row(CFG_GAIN_Y, 65535));
        add_row(cfg_row(CFG_GAIN_HEADING, 65535));
        add_row(item_row(OP_POSE, 8'd0, 32767, -32768, 16385));
        add_row(pinned_row(32767, 32767, 32767, '{0, 0, 0, 1, 0, 1}));
        add_row(cfg_row(CFG_POS_TOL, 32767));
        add_row(cfg_row(CFG_HEAD_TOL, 32767));
        add_row(item_row(OP_POSE, 8'd0, 0, 0, -16384));
        add_row(cfg_row(CFG_GAIN_X, 0));
        add_row(cfg_row(CFG_GAIN_Y, 0));
        add_row(cfg_row(CFG_GAIN_HEADING, 0));
        add_row(item_row(OP_POSE, 8'd0, 5, 5, 16384));
        add_row(cfg_row(CFG_POS_TOL, 0));
        add_row(cfg_row(CFG_HEAD_TOL, 0));
        add_row(cfg_row(CFG_UNUSED, 16'hFFFF));
        add_row(item_row(OP_POSE, 8'd0, -32768, -32768, -32768));
        // A count above the table depth, then a count below the pointer.
        add_row(cfg_row(CFG_WP_COUNT, 16'hFF2C));
        add_row(item_row(OP_POSE, 8'd0, 1234, -4321, 20000));
        add_row(cfg_row(CFG_WP_COUNT, 1));
        add_row(pinned_row(7, 7, 7, '{0, 0, 0, 0, 1, 2}));

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                settle();
                write_reg(directed[i].reg_index, directed[i].reg_data);
            end else begin
                pin_pending = directed[i].pinned;
                pin_cmd = directed[i].pinned_cmd;
                send_item(directed[i].opcode, directed[i].slot, directed[i].px,
                          directed[i].py, directed[i].ph);
            end
        end
        pin_pending = 1'b0;

        // Random phases: new settings, then mostly poses aimed near the target.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            calm = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 9);
            word = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(0, 8192));
            write_reg(CFG_GAIN_X, word);
            word = (sel == 2) ? 16'd0 : (sel == 3) ? 16'hFFFF : 16'($urandom_range(0, 8192));
            write_reg(CFG_GAIN_Y, word);
            word = (sel == 4) ? 16'hFFFF : 16'($urandom);
            write_reg(CFG_GAIN_HEADING, word);
            word = (sel == 5) ? 16'h7FFF : (sel == 6) ? 16'd0 : 16'($urandom_range(20, 1500));
            word[15] = 1'($urandom_range(0, 1));
            write_reg(CFG_POS_TOL, word);
            word = (sel == 7) ? 16'h7FFF : (sel == 6) ? 16'd0 : 16'($urandom_range(50, 4000));
            word[15] = 1'($urandom_range(0, 1));
            write_reg(CFG_HEAD_TOL, word);
            if ($urandom_range(0, 29) == 0) begin
                cnt = $urandom_range(256, 511);
            end else begin
                cnt = target_ptr + $urandom_range(0, 6);
                if (cnt > TABLE_DEPTH) cnt = TABLE_DEPTH;
            end
            eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
            fill_slots(target_ptr, eff);
            word = 16'($urandom);
            word[8:0] = 9'(cnt);
            write_reg(CFG_WP_COUNT, word);
            for (int k = 0; k < 30; k++) begin
                sel = $urandom_range(0, 9);
                wp = target_ptr;
                if (sel < 6 && wp < eff) begin
                    t = $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 3000);
                    send_item(OP_POSE, 8'($urandom),
                              16'(int'(wp_x[wp]) + $urandom_range(0, 2 * t) - t),
                              16'(int'(wp_y[wp]) + $urandom_range(0, 2 * t) - t),
                              16'(int'(wp_h[wp]) + $urandom_range(0, 4 * t) - 2 * t));
                end else if (sel < 8) begin
                    send_item(OP_POSE, 8'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                end else begin
                    send_item(OP_LOAD, 8'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom));
                end
            end
        end

        // Drain and report.
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_cmds.size() == 0) begin
            $display("omni_waypoint_p_controller_core verification clean");
        end else begin
            $display("omni_waypoint_p_controller_core verification failed");
        end
        $finish;
    end

endmodule
